// File: rtl/q4k_pkg.sv
package q4k_pkg;

    localparam int WORDS_PER_BLOCK = 18;
    localparam int RESULTS_PER_WORD = 16;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] HALF_QNAN = 16'hFE00;
    localparam logic [15:0] HALF_QUIET = 16'h0200;
    localparam logic [14:0] HALF_INF = 15'h7C00;

    typedef logic [4:0] t_wpos;

    // one quant word with everything the back end needs to expand it
    typedef struct packed {
        logic [63:0] word;
        logic [15:0] d;
        logic [15:0] dmin;
        logic [5:0]  sc0;
        logic [5:0]  m0;
        logic [5:0]  sc1;
        logic [5:0]  m1;
        logic [7:0]  base;
        logic        end_block;
        logic        end_job;
    } t_job;

    typedef struct packed {
        logic last_of_job;
        logic last_of_block;
        logic last_of_word;
    } t_flags;

    // returns {sc, m} of sub-block j from the twelve packed scale bytes
    function automatic logic [11:0] unpack_scale_min(logic [95:0] q, logic [2:0] j);
        logic [3:0] ja;
        logic [3:0] jb;
        logic [5:0] sc;
        logic [5:0] m;
        ja = {1'b0, j};
        jb = ja + 4'd4;
        if (j[2] == 1'b0) begin
            sc = q[ja*8 +: 6];
            m  = q[jb*8 +: 6];
        end else begin
            sc = {q[(ja - 4'd4)*8 + 6 +: 2], q[jb*8 +: 4]};
            m  = {q[ja*8 + 6 +: 2], q[jb*8 + 4 +: 4]};
        end
        return {sc, m};
    endfunction

endpackage

// File: rtl/q4k_front.sv
module q4k_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [63:0]      i_word,
    input  logic [15:0]      i_block_count,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output q4k_pkg::t_job    o_job
);
    import q4k_pkg::*;

    t_wpos       r_wpos;
    t_wpos       n_wpos;
    logic [15:0] r_blocks_done;
    logic [15:0] n_blocks_done;
    logic [15:0] r_d;
    logic [15:0] r_dmin;
    logic [95:0] r_q;
    logic        accept;
    logic [3:0]  qidx;
    logic [15:0] next_done;
    logic        end_block;
    logic        end_job;
    logic [11:0] sm0;
    logic [11:0] sm1;

    assign o_ready = ~i_q_full;
    assign accept  = i_valid & ~i_q_full;

    always_comb begin
        qidx      = 4'(r_wpos - t_wpos'(2));
        end_block = (r_wpos == t_wpos'(WORDS_PER_BLOCK - 1));
        next_done = r_blocks_done + 16'd1;
        end_job   = end_block & (next_done == i_block_count);
        sm0       = unpack_scale_min(r_q, {qidx[3:2], 1'b0});
        sm1       = unpack_scale_min(r_q, {qidx[3:2], 1'b1});
    end

    always_comb begin
        n_wpos        = r_wpos;
        n_blocks_done = r_blocks_done;
        if (accept) begin
            if (end_block) begin
                n_wpos        = '0;
                n_blocks_done = end_job ? 16'd0 : next_done;
            end else begin
                n_wpos = r_wpos + t_wpos'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos        <= '0;
            r_blocks_done <= '0;
        end else begin
            r_wpos        <= n_wpos;
            r_blocks_done <= n_blocks_done;
        end
    end

    // header words, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && r_wpos == t_wpos'(0)) begin
            r_d        <= i_word[15:0];
            r_dmin     <= i_word[31:16];
            r_q[31:0]  <= i_word[63:32];
        end
        if (accept && r_wpos == t_wpos'(1)) begin
            r_q[95:32] <= i_word;
        end
    end

    assign o_push = accept & (r_wpos >= t_wpos'(2));

    always_comb begin
        o_job.word      = i_word;
        o_job.d         = r_d;
        o_job.dmin      = r_dmin;
        o_job.sc0       = sm0[11:6];
        o_job.m0        = sm0[5:0];
        o_job.sc1       = sm1[11:6];
        o_job.m1        = sm1[5:0];
        o_job.base      = {qidx[3:2], 1'b0, qidx[1:0], 3'b000};
        o_job.end_block = end_block;
        o_job.end_job   = end_job;
    end

endmodule

// File: rtl/q4k_queue.sv
module q4k_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  q4k_pkg::t_job    i_job,
    input  logic             i_pop,
    output q4k_pkg::t_job    o_job,
    output logic             o_full,
    output logic             o_empty
);
    import q4k_pkg::*;

    t_job                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: rtl/q4k_back.sv
module q4k_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  q4k_pkg::t_job    i_job,
    input  logic             i_q_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [15:0]      o_value,
    output logic [7:0]       o_position,
    output q4k_pkg::t_flags  o_flags
);
    import q4k_pkg::*;

    // returns {is_special, fp16} for nan and infinity outcomes
    function automatic logic [16:0] special_case(logic [15:0] d, logic [15:0] dm,
                                                 logic [5:0] sc, logic [5:0] m,
                                                 logic [3:0] v);
        logic        d_nan;
        logic        d_inf;
        logic        n_nan;
        logic        n_inf;
        logic        p_nan;
        logic        p_inf;
        logic [15:0] p_val;
        logic        l_nan;
        logic        l_inf;
        logic [15:0] l_val;
        logic [16:0] res;
        d_nan = (&d[14:10]) & (|d[9:0]);
        d_inf = (&d[14:10]) & ~(|d[9:0]);
        n_nan = (&dm[14:10]) & (|dm[9:0]);
        n_inf = (&dm[14:10]) & ~(|dm[9:0]);
        p_nan = 1'b0;
        p_inf = 1'b0;
        p_val = HALF_QNAN;
        if (d_nan) begin
            p_nan = 1'b1;
            p_val = d | HALF_QUIET;
        end else if (d_inf && (sc == '0 || v == '0)) begin
            p_nan = 1'b1;
        end else if (d_inf) begin
            p_inf = 1'b1;
        end
        l_nan = 1'b0;
        l_inf = 1'b0;
        l_val = HALF_QNAN;
        if (n_nan) begin
            l_nan = 1'b1;
            l_val = dm | HALF_QUIET;
        end else if (n_inf && m == '0) begin
            l_nan = 1'b1;
        end else if (n_inf) begin
            l_inf = 1'b1;
        end
        res = '0;
        priority if (p_nan) begin
            res = {1'b1, p_val};
        end else if (l_nan) begin
            res = {1'b1, l_val};
        end else if (p_inf && l_inf && d[15] == dm[15]) begin
            res = {1'b1, HALF_QNAN};
        end else if (p_inf) begin
            res = {1'b1, d[15], HALF_INF};
        end else if (l_inf) begin
            res = {1'b1, ~dm[15], HALF_INF};
        end else begin
            res = '0;
        end
        return res;
    endfunction

    logic        adv;
    logic        load;
    logic [3:0]  r_k;

    // stage 0: operand select
    logic        r_v0;
    logic [15:0] r0_d;
    logic [15:0] r0_dmin;
    logic [5:0]  r0_sc;
    logic [5:0]  r0_m;
    logic [3:0]  r0_v;
    logic [7:0]  r0_pos;
    t_flags      r0_flags;
    logic [7:0]  sel_byte;

    // stage 1: integer products
    logic        r_v1;
    logic [20:0] r1_p;
    logic [16:0] r1_m;
    logic [4:0]  r1_ep;
    logic [4:0]  r1_em;
    logic        r1_sp;
    logic        r1_sm;
    logic [16:0] r1_spec;
    logic [7:0]  r1_pos;
    t_flags      r1_flags;
    logic [10:0] md;
    logic [10:0] mm;
    logic [9:0]  scv;

    // stage 2: aligned difference
    logic        r_v2;
    logic [50:0] r2_mag;
    logic        r2_sign;
    logic [4:0]  r2_emin;
    logic [16:0] r2_spec;
    logic [7:0]  r2_pos;
    t_flags      r2_flags;
    logic [4:0]  emin;
    logic [49:0] al_a;
    logic [49:0] al_b;
    logic [51:0] sa;
    logic [51:0] sb;
    logic [51:0] diff;

    // stage 3: normalize and round to single precision
    logic               r_v3;
    logic [23:0]        r3_mant;
    logic signed [7:0]  r3_e;
    logic               r3_sign;
    logic               r3_zero;
    logic [16:0]        r3_spec;
    logic [7:0]         r3_pos;
    t_flags             r3_flags;
    logic [5:0]         lead;
    logic [50:0]        norm;
    logic [24:0]        rsum;
    logic               rnd32;
    logic signed [7:0]  e_lead;

    // stage 4: round to half, output register
    logic               r_v4;
    logic [15:0]        r4_value;
    logic [7:0]         r4_pos;
    t_flags             r4_flags;
    logic [15:0]        half;
    logic [4:0]         sh;
    logic [47:0]        shf;
    logic               rnd16;
    logic [4:0]         ebase;

    assign adv   = ~r_v4 | i_ready;
    assign load  = adv & ~i_q_empty;
    assign o_pop = load & (r_k == 4'(RESULTS_PER_WORD - 1));

    always_comb begin
        sel_byte = i_job.word[r_k[2:0]*8 +: 8];
    end

    always_comb begin
        md  = (r0_d[14:10] == '0) ? {1'b0, r0_d[9:0]} : {1'b1, r0_d[9:0]};
        mm  = (r0_dmin[14:10] == '0) ? {1'b0, r0_dmin[9:0]} : {1'b1, r0_dmin[9:0]};
        scv = 10'(r0_sc) * 10'(r0_v);
    end

    always_comb begin
        emin = (r1_ep < r1_em) ? r1_ep : r1_em;
        al_a = 50'(r1_p) << (r1_ep - emin);
        al_b = 50'(r1_m) << (r1_em - emin);
        sa   = r1_sp ? -{2'b00, al_a} : {2'b00, al_a};
        sb   = r1_sm ? -{2'b00, al_b} : {2'b00, al_b};
        diff = sa - sb;
    end

    always_comb begin
        lead = '0;
        for (int i = 0; i < 51; i++) begin
            if (r2_mag[i]) begin
                lead = 6'(i);
            end
        end
        norm   = r2_mag << (6'd50 - lead);
        e_lead = $signed({3'b000, r2_emin}) - 8'sd24 + $signed({2'b00, lead});
        rnd32  = norm[26] & ((|norm[25:0]) | norm[27]);
        rsum   = {1'b0, norm[50:27]} + 25'(rnd32);
    end

    always_comb begin
        sh    = (r3_e >= -8'sd14) ? 5'd13 : 5'(-8'sd1 - r3_e);
        shf   = {r3_mant, 24'b0} >> sh;
        rnd16 = shf[23] & ((|shf[22:0]) | shf[24]);
        ebase = (r3_e >= -8'sd14) ? 5'(r3_e + 8'sd14) : 5'd0;
        priority if (r3_spec[16]) begin
            half = r3_spec[15:0];
        end else if (r3_zero || r3_e < -8'sd25) begin
            half = {r3_sign, 15'b0};
        end else if (r3_e > 8'sd15) begin
            half = {r3_sign, HALF_INF};
        end else begin
            half = {r3_sign, 15'({ebase, 10'b0}) + shf[38:24] + 15'(rnd16)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            if (load) begin
                r_k <= r_k + 4'd1;
            end
            r_v0 <= load;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_d                   <= i_job.d;
            r0_dmin                <= i_job.dmin;
            r0_sc                  <= r_k[3] ? i_job.sc1 : i_job.sc0;
            r0_m                   <= r_k[3] ? i_job.m1 : i_job.m0;
            r0_v                   <= r_k[3] ? sel_byte[7:4] : sel_byte[3:0];
            r0_pos                 <= i_job.base + {2'b00, r_k[3], 2'b00, r_k[2:0]};
            r0_flags.last_of_word  <= (r_k == 4'(RESULTS_PER_WORD - 1));
            r0_flags.last_of_block <= (r_k == 4'(RESULTS_PER_WORD - 1)) & i_job.end_block;
            r0_flags.last_of_job   <= (r_k == 4'(RESULTS_PER_WORD - 1)) & i_job.end_job;

            r1_p     <= 21'(md) * 21'(scv);
            r1_m     <= 17'(mm) * 17'(r0_m);
            r1_ep    <= (r0_d[14:10] == '0) ? 5'd0 : r0_d[14:10] - 5'd1;
            r1_em    <= (r0_dmin[14:10] == '0) ? 5'd0 : r0_dmin[14:10] - 5'd1;
            r1_sp    <= r0_d[15];
            r1_sm    <= r0_dmin[15];
            r1_spec  <= special_case(r0_d, r0_dmin, r0_sc, r0_m, r0_v);
            r1_pos   <= r0_pos;
            r1_flags <= r0_flags;

            r2_mag   <= diff[51] ? 51'(-diff) : diff[50:0];
            r2_sign  <= (diff == '0) ? (r1_sp & ~r1_sm & (r1_p == '0) & (r1_m == '0))
                                     : diff[51];
            r2_emin  <= emin;
            r2_spec  <= r1_spec;
            r2_pos   <= r1_pos;
            r2_flags <= r1_flags;

            r3_mant  <= rsum[24] ? 24'h800000 : rsum[23:0];
            r3_e     <= rsum[24] ? e_lead + 8'sd1 : e_lead;
            r3_sign  <= r2_sign;
            r3_zero  <= (r2_mag == '0);
            r3_spec  <= r2_spec;
            r3_pos   <= r2_pos;
            r3_flags <= r2_flags;

            r4_value <= half;
            r4_pos   <= r3_pos;
            r4_flags <= r3_flags;
        end
    end

    assign o_valid    = r_v4;
    assign o_value    = r4_value;
    assign o_position = r4_pos;
    assign o_flags    = r4_flags;

endmodule

// File: rtl/q4_k_superblock_dequantizer_unit.sv
// channel   dir  handshake                    payload
// s (in)    in   i_s_tvalid / o_s_tready      i_s_tdata[63:0] data_word
// m (out)   out  o_m_tvalid / i_m_tready      o_m_tdata value, position; tuser, tlast flags
// apb       in   psel/penable/pwrite/pready   block_count at byte address 0
//
// header words (0 and 1 of a superblock) give no result
// a quant word gives sixteen results, one per cycle while the output is not stalled;
// the first result is registered in the queue and then in stages 0 to 4 before it appears
// a two-word queue parts the front from the five-stage fp back pipeline
// synchronous active-low reset clears counters, queue and pipeline valids
// a stalled output freezes the back pipeline; the front keeps taking words until the queue fills
module q4_k_superblock_dequantizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] data_word
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] value, [23:16] position
    output logic [1:0]  o_m_tuser,   // [0] last_of_word, [1] last_of_block
    output logic        o_m_tlast,   // last_of_job
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import q4k_pkg::*;

    logic [15:0] r_block_count;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    t_job        push_job;
    t_job        head_job;
    logic [15:0] value;
    logic [7:0]  position;
    t_flags      flags;

    // block count register, one word at address zero
    assign pready = 1'b1;
    assign prdata = {16'b0, r_block_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= 16'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_block_count <= pwdata[15:0];
        end
    end

    // front: word position, header capture, scale unpack
    q4k_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .i_word        (i_s_tdata),
        .i_block_count (r_block_count),
        .i_q_full      (q_full),
        .o_ready       (o_s_tready),
        .o_push        (push),
        .o_job         (push_job)
    );

    q4k_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: sixteen results per queued word
    q4k_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_value    (value),
        .o_position (position),
        .o_flags    (flags)
    );

    assign o_m_tdata = {position, value};
    assign o_m_tuser = {flags.last_of_block, flags.last_of_word};
    assign o_m_tlast = flags.last_of_job;

endmodule

// File: rtl/q4k_checker.sv
module q4k_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed under stall");

    a_job_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[1])
        else $error("job end off a superblock end");

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0] && o_m_tdata[23:16] == 8'hFF)
        else $error("superblock end not at last position");

    a_word_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[18:16] == 3'b111 && o_m_tdata[21] == 1'b1)
        else $error("word end at wrong position");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind q4_k_superblock_dequantizer_unit q4k_checker u_q4k_checker (.*);
